### rtl/trfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfb_pkg
// Shared types and constants of the token ring frame builder: byte kinds,
// the frame start byte and the command passed from front end to back end.
// ----------------------------------------------------------------------------
package trfb_pkg;

   localparam int ADDR_WIDTH          = 7;
   localparam int BYTE_WIDTH          = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [BYTE_WIDTH-1:0] START_BYTE = 8'hAA;

   typedef enum logic [2:0] {
      KIND_START   = 3'd0,
      KIND_SOURCE  = 3'd1,
      KIND_DEST    = 3'd2,
      KIND_LENGTH  = 3'd3,
      KIND_PAYLOAD = 3'd4,
      KIND_CHECK   = 3'd5
   } kind_type;

   // one queued command: all bytes that one accepted transaction produces
   typedef struct packed {
      logic                  is_start;
      logic [ADDR_WIDTH-1:0] source;
      logic [ADDR_WIDTH-1:0] destination;
      logic [BYTE_WIDTH-1:0] length;
      logic                  has_payload;
      logic [BYTE_WIDTH-1:0] payload;
      logic                  has_check;
      logic [BYTE_WIDTH-1:0] check;
   } cmd_type;

endpackage

### rtl/trfb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfb_front
// Front end: accepts transactions, tracks the open frame and its checksum,
// and turns each start or open-frame transaction into one back end command.
// ----------------------------------------------------------------------------
module trfb_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           starts_message,
   input  logic [trfb_pkg::ADDR_WIDTH-1:0] destination,
   input  logic [trfb_pkg::BYTE_WIDTH-1:0] message_length,
   input  logic [trfb_pkg::BYTE_WIDTH-1:0] payload_byte,
   input  logic [trfb_pkg::ADDR_WIDTH-1:0] source_address,
   output logic                           cmd_push,
   output trfb_pkg::cmd_type              cmd
);
   import trfb_pkg::*;

   logic                  open_ff, open_in;
   logic [BYTE_WIDTH-1:0] remaining_ff, remaining_in;
   logic [BYTE_WIDTH-1:0] checksum_ff, checksum_in;
   logic [BYTE_WIDTH-1:0] header_sum;
   logic [BYTE_WIDTH-1:0] payload_sum;
   logic                  len_zero;
   logic                  len_one;

   assign header_sum  = {1'b0, source_address} ^ {1'b0, destination} ^ message_length;
   assign payload_sum = (starts_message ? header_sum : checksum_ff) ^ payload_byte;
   assign len_zero    = (message_length == '0);
   assign len_one     = (message_length == BYTE_WIDTH'(1));

   always_comb begin
      open_in          = open_ff;
      remaining_in     = remaining_ff;
      checksum_in      = checksum_ff;
      cmd_push         = 1'b0;
      cmd.is_start     = starts_message;
      cmd.source       = source_address;
      cmd.destination  = destination;
      cmd.length       = message_length;
      cmd.has_payload  = 1'b1;
      cmd.payload      = payload_byte;
      cmd.has_check    = 1'b0;
      cmd.check        = payload_sum;
      if (starts_message) begin
         // new start abandons any open frame
         cmd.has_payload = !len_zero;
         cmd.has_check   = len_zero || len_one;
         cmd.check       = len_zero ? header_sum : payload_sum;
         if (accept) begin
            cmd_push     = 1'b1;
            open_in      = !len_zero && !len_one;
            remaining_in = len_zero ? '0 : message_length - BYTE_WIDTH'(1);
            checksum_in  = payload_sum;
         end
      end else if (open_ff) begin
         cmd.has_check = (remaining_ff == BYTE_WIDTH'(1));
         if (accept) begin
            cmd_push     = 1'b1;
            open_in      = (remaining_ff != BYTE_WIDTH'(1));
            remaining_in = remaining_ff - BYTE_WIDTH'(1);
            checksum_in  = payload_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= 1'b0;
         remaining_ff <= '0;
         checksum_ff  <= '0;
      end else begin
         open_ff      <= open_in;
         remaining_ff <= remaining_in;
         checksum_ff  <= checksum_in;
      end
   end

endmodule

### rtl/trfb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfb_queue
// Short command queue between front end and back end.
// ----------------------------------------------------------------------------
module trfb_queue #(
   parameter int Depth = trfb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  trfb_pkg::cmd_type push_cmd,
   input  logic              pop,
   output trfb_pkg::cmd_type head_cmd,
   output logic              head_valid,
   output logic              full
);
   import trfb_pkg::*;

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);

   cmd_type               mem_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full       = (count_ff == CountWidth'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CountWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/trfb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trfb_back
// Back end: steps through the bytes of the head command into the result
// register, one per cycle while the result register is free or popped.
// ----------------------------------------------------------------------------
module trfb_back (
   input  logic                            clock,
   input  logic                            reset,
   input  trfb_pkg::cmd_type               head_cmd,
   input  logic                            head_valid,
   output logic                            head_pop,
   input  logic                            rsp_pop,
   output logic                            rsp_valid,
   output logic [trfb_pkg::BYTE_WIDTH-1:0] rsp_byte,
   output trfb_pkg::kind_type              rsp_kind,
   output logic                            rsp_last
);
   import trfb_pkg::*;

   logic                  active_ff;
   kind_type              step_ff;
   logic                  out_valid_ff;
   logic [BYTE_WIDTH-1:0] out_byte_ff;
   kind_type              out_kind_ff;
   logic                  out_last_ff;

   kind_type              cur_kind;
   kind_type              next_kind;
   logic                  cur_last;
   logic [BYTE_WIDTH-1:0] cur_byte;
   logic                  load;

   assign cur_kind = active_ff ? step_ff : (head_cmd.is_start ? KIND_START : KIND_PAYLOAD);
   assign load     = head_valid && (!out_valid_ff || rsp_pop);
   assign head_pop = load && cur_last;

   always_comb begin
      next_kind = KIND_START;
      cur_last  = 1'b0;
      cur_byte  = START_BYTE;
      case (cur_kind)
         KIND_START: begin
            next_kind = KIND_SOURCE;
         end
         KIND_SOURCE: begin
            next_kind = KIND_DEST;
            cur_byte  = {1'b0, head_cmd.source};
         end
         KIND_DEST: begin
            next_kind = KIND_LENGTH;
            cur_byte  = {1'b0, head_cmd.destination};
         end
         KIND_LENGTH: begin
            next_kind = head_cmd.has_payload ? KIND_PAYLOAD : KIND_CHECK;
            cur_byte  = head_cmd.length;
         end
         KIND_PAYLOAD: begin
            next_kind = KIND_CHECK;
            cur_last  = !head_cmd.has_check;
            cur_byte  = head_cmd.payload;
         end
         KIND_CHECK: begin
            cur_last  = 1'b1;
            cur_byte  = head_cmd.check;
         end
         default: begin
            cur_last  = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         step_ff      <= KIND_START;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            active_ff    <= !cur_last;
            step_ff      <= next_kind;
            out_valid_ff <= 1'b1;
            out_byte_ff  <= cur_byte;
            out_kind_ff  <= cur_kind;
            out_last_ff  <= cur_last;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_byte  = out_byte_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_last  = out_last_ff;

endmodule

### rtl/token_ring_frame_builder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_ring_frame_builder_core
// Serial frame builder: header, payload bytes and XOR checksum per frame.
// ----------------------------------------------------------------------------
// a start transaction yields five or six result bytes (start byte 0xaa,
// source, destination, length, then the first payload byte and/or the
// checksum); a payload transaction yields one byte, two when it closes the
// frame; a byte with no open frame yields nothing. the front end takes one
// transaction per cycle while the command queue has room; the back end puts
// out one result byte per cycle while results are popped, so a payload
// stream runs at one transaction per cycle and a start transaction holds
// the back end for five or six bytes, during which the input stalls once
// the queue has filled. results pass through the queue, then the result
// register. source address is taken from the csr register at accept time
// ----------------------------------------------------------------------------
module token_ring_frame_builder_core #(
   parameter int QueueDepth = trfb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // configuration
   input  logic                            csr_write_enable,
   input  logic [trfb_pkg::ADDR_WIDTH-1:0] csr_source_address,
   // request queue side
   input  logic                            push,
   output logic                            full,
   input  logic                            req_starts_message,
   input  logic [trfb_pkg::ADDR_WIDTH-1:0] req_destination,
   input  logic [trfb_pkg::BYTE_WIDTH-1:0] req_message_length,
   input  logic [trfb_pkg::BYTE_WIDTH-1:0] req_payload_byte,
   // response queue side
   output logic                            empty,
   input  logic                            pop,
   output logic [trfb_pkg::BYTE_WIDTH-1:0] rsp_out_byte,
   output logic [2:0]                      rsp_byte_kind,
   output logic                            rsp_last_of_run
);
   import trfb_pkg::*;

   // source address register
   logic [ADDR_WIDTH-1:0] source_address_ff;

   // front end to queue
   logic    cmd_push;
   cmd_type cmd;
   logic    accept;

   // queue to back end
   cmd_type  head_cmd;
   logic     head_valid;
   logic     head_pop;
   logic     out_valid;
   kind_type out_kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_address_ff <= '0;
      end else if (csr_write_enable) begin
         source_address_ff <= csr_source_address;
      end
   end

   // a transaction is taken whenever the queue has room, even if dropped
   assign accept = push && !full;

   trfb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .starts_message (req_starts_message),
      .destination    (req_destination),
      .message_length (req_message_length),
      .payload_byte   (req_payload_byte),
      .source_address (source_address_ff),
      .cmd_push       (cmd_push),
      .cmd            (cmd)
   );

   trfb_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (cmd),
      .pop        (head_pop),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .full       (full)
   );

   // back end expands each command into its result bytes
   trfb_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .rsp_pop    (pop),
      .rsp_valid  (out_valid),
      .rsp_byte   (rsp_out_byte),
      .rsp_kind   (out_kind),
      .rsp_last   (rsp_last_of_run)
   );

   assign empty         = !out_valid;
   assign rsp_byte_kind = out_kind;

endmodule
